@@ design/frac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_pkg
// Types and codes shared by the flow record aggregation cache.
// ----------------------------------------------------------------------------
package frac_pkg;

    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_UPDATED     = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
    localparam logic [2:0] ST_EXPIRED     = 3'd3;
    localparam logic [2:0] ST_NOT_EXPIRED = 3'd4;

    localparam logic [7:0] AGG_SUM = 8'd1;
    localparam logic [7:0] AGG_MIN = 8'd2;
    localparam logic [7:0] AGG_MAX = 8'd4;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    localparam logic REG_IDLE_LIMIT  = 1'b0;
    localparam logic REG_SAMPLE_INTV = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] pkt_key;
        logic [23:0] metric_id;
        logic [7:0]  aggregator_code;
        logic [31:0] indicator_value;
        logic [3:0]  error_flags;
        logic [47:0] now_ms;
        logic [5:0]  sweep_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        raw_export_due;
        logic [5:0]  slot;
        logic [63:0] out_flow_key;
        logic [23:0] out_indicator_id;
        logic [7:0]  out_aggregator;
        logic [63:0] out_value;
        logic [31:0] out_packet_count;
        logic [63:0] out_error_counts;
        logic [47:0] out_start_ms;
        logic [47:0] out_end_ms;
    } out_item_t;

    // one flow record as held in the record memory
    typedef struct packed {
        logic [63:0] key;
        logic [23:0] id;
        logic [7:0]  aggr;
        logic [63:0] value;
        logic [31:0] count;
        logic [63:0] errors;
        logic [47:0] start_ms;
        logic [47:0] end_ms;
        logic [31:0] last_export;
    } rec_t;

    typedef struct packed {
        logic cap;
        logic match;
        logic read;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

@@ design/frac_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module frac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/frac_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_ctrl
// Sequencer: accept, match, record read, commit.
// ----------------------------------------------------------------------------
module frac_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  frac_pkg::sts_t     sts,
    output frac_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.cap = s_valid;
                if (s_valid) begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH: begin
                cmd.match  = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register is free
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

@@ design/frac_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_dpath
// Match array, record memory, aggregation and result register.
// ----------------------------------------------------------------------------
module frac_dpath #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  frac_pkg::cmd_t      cmd,
    output frac_pkg::sts_t      sts,
    input  frac_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output frac_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    frac_pkg::in_item_t  in_reg;
    frac_pkg::out_item_t m_data_reg, m_data_next;
    logic                m_valid_reg;
    logic [31:0]         idle_limit_reg;
    logic [15:0]         interval_reg;

    logic [KEY_BITS-1:0] cam_key_reg  [TABLE_ENTRIES];
    logic [23:0]         cam_id_reg   [TABLE_ENTRIES];
    logic [7:0]          cam_aggr_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic          hit_reg, free_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic          hit_c, free_c;
    logic [IW-1:0] hit_idx_c, free_idx_c;

    logic [KEY_BITS-1:0] in_key;
    logic [IW-1:0]       sw_idx;
    logic                sw_live;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    frac_pkg::rec_t      rd_rec, wr_rec;

    logic                is_insert, is_update, is_full, is_expired;
    logic [64:0]         sum65;
    logic [63:0]         agg_value;
    logic [63:0]         err_bumped, err_init;
    logic [31:0]         new_count, delta;
    logic                due;
    logic [47:0]         idle;

    assign in_key  = in_reg.pkt_key[KEY_BITS-1:0];
    assign sw_idx  = in_reg.sweep_slot[IW-1:0];
    assign sw_live = (7'(in_reg.sweep_slot) < 7'(TABLE_ENTRIES)) && valid_reg[sw_idx];

    // lowest matching and lowest free slot
    always_comb begin
        hit_c      = 1'b0;
        free_c     = 1'b0;
        hit_idx_c  = '0;
        free_idx_c = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i]) begin
                if (cam_key_reg[i] == in_key && cam_id_reg[i] == in_reg.metric_id
                    && cam_aggr_reg[i] == in_reg.aggregator_code) begin
                    hit_c     = 1'b1;
                    hit_idx_c = IW'(i);
                end
            end else begin
                free_c     = 1'b1;
                free_idx_c = IW'(i);
            end
        end
    end

    assign ram_raddr = (in_reg.kind == frac_pkg::KIND_SWEEP) ? sw_idx : hit_idx_reg;

    frac_ram #(
        .WIDTH ($bits(frac_pkg::rec_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_rec),
        .re    (cmd.read),
        .raddr (ram_raddr),
        .rdata (rd_rec)
    );

    always_comb begin
        is_insert  = (in_reg.kind == frac_pkg::KIND_PACKET) && !hit_reg && free_reg;
        is_update  = (in_reg.kind == frac_pkg::KIND_PACKET) && hit_reg;
        is_full    = (in_reg.kind == frac_pkg::KIND_PACKET) && !hit_reg && !free_reg;
        idle       = in_reg.now_ms - rd_rec.end_ms;
        is_expired = (in_reg.kind == frac_pkg::KIND_SWEEP) && sw_live
                     && (idle > 48'(idle_limit_reg));

        sum65 = {1'b0, rd_rec.value} + 65'(in_reg.indicator_value);
        case (in_reg.aggregator_code)
            frac_pkg::AGG_SUM: agg_value = sum65[64] ? '1 : sum65[63:0];
            frac_pkg::AGG_MIN: agg_value = (64'(in_reg.indicator_value) < rd_rec.value)
                                           ? 64'(in_reg.indicator_value) : rd_rec.value;
            frac_pkg::AGG_MAX: agg_value = (64'(in_reg.indicator_value) > rd_rec.value)
                                           ? 64'(in_reg.indicator_value) : rd_rec.value;
            default:           agg_value = rd_rec.value;
        endcase

        err_bumped = rd_rec.errors;
        err_init   = '0;
        for (int b = 0; b < 4; b++) begin
            err_init[16*b] = in_reg.error_flags[b];
            if (in_reg.error_flags[b] && rd_rec.errors[16*b +: 16] != 16'hFFFF) begin
                err_bumped[16*b +: 16] = rd_rec.errors[16*b +: 16] + 16'd1;
            end
        end

        new_count = (rd_rec.count == 32'hFFFF_FFFF) ? rd_rec.count : rd_rec.count + 32'd1;
        delta     = new_count - rd_rec.last_export;
        due       = (delta >= 32'(interval_reg)) || (rd_rec.last_export == 32'd0);

        wr_rec = rd_rec;
        if (is_insert) begin
            wr_rec.key         = 64'(in_key);
            wr_rec.id          = in_reg.metric_id;
            wr_rec.aggr        = in_reg.aggregator_code;
            wr_rec.value       = (in_reg.error_flags != 4'd0) ? 64'd0
                                 : 64'(in_reg.indicator_value);
            wr_rec.count       = 32'd1;
            wr_rec.errors      = err_init;
            wr_rec.start_ms    = in_reg.now_ms;
            wr_rec.end_ms      = in_reg.now_ms;
            wr_rec.last_export = 32'd1;
        end else begin
            if (in_reg.error_flags != 4'd0) begin
                wr_rec.errors = err_bumped;
            end else begin
                wr_rec.value = agg_value;
            end
            wr_rec.count  = new_count;
            wr_rec.end_ms = in_reg.now_ms;
            if (due) begin
                wr_rec.last_export = new_count;
            end
        end

        ram_we    = cmd.commit && (is_insert || is_update);
        ram_waddr = is_insert ? free_idx_reg : hit_idx_reg;

        m_data_next = '0;
        if (in_reg.kind == frac_pkg::KIND_SWEEP) begin
            m_data_next.slot = in_reg.sweep_slot;
            if (is_expired) begin
                m_data_next.status           = frac_pkg::ST_EXPIRED;
                m_data_next.out_flow_key     = rd_rec.key;
                m_data_next.out_indicator_id = rd_rec.id;
                m_data_next.out_aggregator   = rd_rec.aggr;
                m_data_next.out_value        = rd_rec.value;
                m_data_next.out_packet_count = rd_rec.count;
                m_data_next.out_error_counts = rd_rec.errors;
                m_data_next.out_start_ms     = rd_rec.start_ms;
                m_data_next.out_end_ms       = rd_rec.end_ms;
            end else begin
                m_data_next.status = frac_pkg::ST_NOT_EXPIRED;
            end
        end else if (is_full) begin
            m_data_next.status = frac_pkg::ST_TABLE_FULL;
        end else if (is_insert) begin
            m_data_next.status         = frac_pkg::ST_INSERTED;
            m_data_next.raw_export_due = 1'b1;
            m_data_next.slot           = 6'(free_idx_reg);
        end else begin
            m_data_next.status         = frac_pkg::ST_UPDATED;
            m_data_next.raw_export_due = due;
            m_data_next.slot           = 6'(hit_idx_reg);
        end

        valid_next = valid_reg;
        if (cmd.commit && is_insert) begin
            valid_next[free_idx_reg] = 1'b1;
        end
        if (cmd.commit && is_expired) begin
            valid_next[sw_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            idle_limit_reg <= 32'd30000;
            interval_reg   <= 16'd100;
        end else begin
            valid_reg <= valid_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    frac_pkg::REG_IDLE_LIMIT:  idle_limit_reg <= cfg_wdata;
                    frac_pkg::REG_SAMPLE_INTV: interval_reg   <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            in_reg <= s_data;
        end
        if (cmd.match) begin
            hit_reg      <= hit_c;
            hit_idx_reg  <= hit_idx_c;
            free_reg     <= free_c;
            free_idx_reg <= free_idx_c;
        end
        if (cmd.commit) begin
            m_data_reg <= m_data_next;
        end
        if (cmd.commit && is_insert) begin
            cam_key_reg[free_idx_reg]  <= in_key;
            cam_id_reg[free_idx_reg]   <= in_reg.metric_id;
            cam_aggr_reg[free_idx_reg] <= in_reg.aggregator_code;
        end
    end

    assign sts.out_busy = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

`ifndef SYNTHESIS
    a_insert_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && is_insert |=> valid_reg[$past(free_idx_reg)])
        else $error("inserted slot not marked valid");

    a_expire_clears_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && is_expired |=> !valid_reg[$past(sw_idx)])
        else $error("expired slot still valid");

    a_full_keeps_table: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && is_full |=> $stable(valid_reg))
        else $error("table changed on a full drop");

    a_commit_sets_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit produced no result");
`endif

endmodule

@@ design/flow_record_aggregation_cache_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_record_aggregation_cache_top
// Flow table with sum/min/max aggregation, sampled raw export and idle expiry.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request: a packet update (kind 0) or an
//   expiry sweep of one slot (kind 1). m_valid/m_ready/m_data return exactly
//   one result per request.
//   cfg_we/cfg_index/cfg_wdata write idle_limit_ms (index 0) or
//   raw_sample_interval (index 1); write only while the block is idle.
//   Each request passes from acceptance to result through capture, a
//   parallel compare against all slots, a read of the record memory and a
//   commit that writes the record back. The compare result and the read of
//   the record memory are registered; a new request is taken only after the
//   commit of the previous one.
//   The result register frees the sequencer: the next request is accepted
//   while a result waits. If the receiver still holds the previous result at
//   commit time, the commit waits until it is taken.
//   Reset clears all slot valid bits and loads idle_limit_ms = 30000 and
//   raw_sample_interval = 100; the record memory needs no clearing.
// ----------------------------------------------------------------------------
module flow_record_aggregation_cache_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  frac_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output frac_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata
);

    frac_pkg::cmd_t cmd;
    frac_pkg::sts_t sts;

    frac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    frac_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
